/* rtl/ffba_pkg.sv */
// Shared types, constants and command codes of the first-fit bin allocator.
package ffba_pkg;

  // Field widths that the interface fixes.
  localparam int CAP_W      = 16;
  localparam int COUNT_W    = 11;
  localparam int IDX_W      = 10;
  localparam int USED_W     = 11;
  localparam int SLACK_W    = 26;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters and the register reset values.
  localparam int DEF_MAX_BINS   = 1024;
  localparam int DEF_SIZE_WIDTH = 16;
  localparam int DEF_CAPACITY   = 100;
  localparam int DEF_COUNT      = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 1'b0,
    REG_COUNT    = 1'b1
  } cfg_reg_e;

  // Request codes carried by the operation field.
  typedef enum logic {
    OPER_PLACE   = 1'b0,
    OPER_RESTART = 1'b1
  } oper_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_PLACE,
    DP_RESTART,
    DP_SWEEP,
    DP_ROOT,
    DP_CHECK,
    DP_DESC,
    DP_LEAF,
    DP_ASCEND,
    DP_MUL,
    DP_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  // Datapath flags the controller branches on.
  typedef struct packed {
    logic fit;          // value read back is at least the item size
    logic child_leaf;   // the node chosen in this descent step is a bin
    logic parent_root;  // the node written in this ascent step is the root
    logic sweep_last;   // the fill pass is at its last entry
  } status_t;

endpackage

/* rtl/ffba_ctrl.sv */
// Sequencer of the first-fit bin allocator: fill pass, tree descent and ascent, result hand-off.
module ffba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ffba_pkg::status_t status_i,
  output ffba_pkg::cmd_t    cmd_o
);
  import ffba_pkg::*;

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_CLEAR  = 10'b00_0000_0100,
    S_ROOT   = 10'b00_0000_1000,
    S_CHECK  = 10'b00_0001_0000,
    S_DESC   = 10'b00_0010_0000,
    S_LEAF   = 10'b00_0100_0000,
    S_ASCEND = 10'b00_1000_0000,
    S_MUL    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        load;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Next state and the command for the datapath.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_IDLE;
    load      = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = DP_SWEEP;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OPER_RESTART) begin
            cmd_o.op = DP_RESTART;
            state_d  = S_CLEAR;
          end else begin
            cmd_o.op = DP_PLACE;
            state_d  = S_ROOT;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.op = DP_SWEEP;
        if (status_i.sweep_last) begin
          state_d = S_MUL;
        end
      end
      S_ROOT: begin
        cmd_o.op = DP_ROOT;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.op = DP_CHECK;
        state_d  = status_i.fit ? S_DESC : S_MUL;
      end
      S_DESC: begin
        cmd_o.op = DP_DESC;
        if (status_i.child_leaf) begin
          state_d = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd_o.op = DP_LEAF;
        state_d  = S_ASCEND;
      end
      S_ASCEND: begin
        cmd_o.op = DP_ASCEND;
        if (status_i.parent_root) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = DP_LOAD;
          load     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, cleared when the receiver takes the beat.
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/ffba_dpath.sv */
// Datapath of the first-fit bin allocator: max-tree memory, path registers and result registers.
module ffba_dpath #(
  parameter int MAX_BINS   = ffba_pkg::DEF_MAX_BINS,
  parameter int SIZE_WIDTH = ffba_pkg::DEF_SIZE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ffba_pkg::cmd_t                   cmd_i,
  output ffba_pkg::status_t                status_o,
  input  logic                             cfg_we_i,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [SIZE_WIDTH-1:0]            item_size_i,
  output logic [ffba_pkg::IDX_W-1:0]       bin_index_o,
  output logic                             fits_o,
  output logic [ffba_pkg::USED_W-1:0]      used_bins_o,
  output logic [ffba_pkg::SLACK_W-1:0]     slack_total_o
);
  import ffba_pkg::*;

  // Leaves are padded up to a power of two; node 1 is the root, leaves sit at
  // nodes 2**BIN_W and up. Entry 0 is never used.
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int TREE_AW   = BIN_W + 1;
  localparam int TREE_SIZE = 2 ** TREE_AW;
  localparam int CNT_W     = BIN_W + 1;
  localparam int PROD_W    = CNT_W + SIZE_WIDTH;
  localparam int InitCount = (DEF_COUNT > MAX_BINS) ? MAX_BINS : DEF_COUNT;

  // Tree memory.
  logic [SIZE_WIDTH-1:0] mem [TREE_SIZE];
  logic [TREE_AW-1:0]    rd_addr;
  logic [SIZE_WIDTH-1:0] rd_data_q;
  logic                  wr_en;
  logic [TREE_AW-1:0]    wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;

  // Configuration and live settings.
  logic [CAP_W-1:0]      cfg_cap_q;
  logic [COUNT_W-1:0]    cfg_cnt_q;
  logic [SIZE_WIDTH-1:0] live_cap_q;
  logic [CNT_W-1:0]      live_cnt_q;
  logic [CNT_W-1:0]      cnt_clamped;

  // Running state and per-request registers.
  logic [CNT_W-1:0]      hu_q, hu_d;
  logic [SLACK_W-1:0]    vol_q;
  logic [TREE_AW-1:0]    sweep_q;
  logic [SIZE_WIDTH-1:0] size_q;
  logic [TREE_AW-1:0]    node_q;
  logic [SIZE_WIDTH-1:0] cur_q;
  logic [BIN_W-1:0]      bin_q;
  logic                  fits_q;
  logic [SLACK_W-1:0]    prod_q;

  // Output registers.
  logic [IDX_W-1:0]      bin_index_q;
  logic                  fits_out_q;
  logic [USED_W-1:0]     used_bins_q;
  logic [SLACK_W-1:0]    slack_q;

  // Derived values.
  logic                  fit;
  logic [TREE_AW-1:0]    child;
  logic [TREE_AW-1:0]    parent;
  logic [SIZE_WIDTH-1:0] up_val;
  logic [SIZE_WIDTH-1:0] leaf_new;
  logic [SIZE_WIDTH-1:0] sweep_val;
  logic [TREE_AW-1:0]    sweep_leaf;
  logic                  sweep_in_range;
  logic [CNT_W-1:0]      bin_next;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W+SLACK_W-1:0] prod_ext;
  logic [BIN_W+IDX_W-1:0]    bin_ext;
  logic [CNT_W+USED_W-1:0]   hu_ext;

  assign fit      = (rd_data_q >= size_q);
  assign child    = {node_q[BIN_W-1:0], !fit};
  assign parent   = node_q >> 1;
  assign up_val   = (rd_data_q > cur_q) ? rd_data_q : cur_q;
  assign leaf_new = rd_data_q - size_q;

  assign status_o.fit         = fit;
  assign status_o.child_leaf  = child[BIN_W];
  assign status_o.parent_root = (parent == TREE_AW'(1));
  assign status_o.sweep_last  = (sweep_q == TREE_AW'(TREE_SIZE - 1));

  // Leftmost bin below the entry being filled: shift the node down to the leaf level.
  always_comb begin
    sweep_leaf = sweep_q;
    for (int l = 0; l < BIN_W; l++) begin
      if (!sweep_leaf[BIN_W]) begin
        sweep_leaf = sweep_leaf << 1;
      end
    end
  end

  // Fill value: a node that covers at least one bin in use gets the capacity,
  // a node that covers only padding bins gets zero.
  assign sweep_in_range = ({1'b0, sweep_leaf[BIN_W-1:0]} < live_cnt_q);
  assign sweep_val      = sweep_in_range ? live_cap_q : '0;

  // Bin count clamped to the range the tree holds.
  always_comb begin
    if (cfg_cnt_q == '0) begin
      cnt_clamped = CNT_W'(1);
    end else if (int'(cfg_cnt_q) > MAX_BINS) begin
      cnt_clamped = CNT_W'(MAX_BINS);
    end else begin
      cnt_clamped = CNT_W'(cfg_cnt_q);
    end
  end

  // Highest used bin after a placement.
  assign bin_next = CNT_W'(node_q[BIN_W-1:0]) + CNT_W'(1);
  assign hu_d     = (bin_next > hu_q) ? bin_next : hu_q;

  // Used bins times capacity, kept modulo the slack width.
  assign prod     = hu_q * live_cap_q;
  assign prod_ext = {{SLACK_W{1'b0}}, prod};
  assign bin_ext  = {{IDX_W{1'b0}}, bin_q};
  assign hu_ext   = {{USED_W{1'b0}}, hu_q};

  // Memory address and write selection per command.
  always_comb begin
    rd_addr = TREE_AW'(1);
    wr_en   = 1'b0;
    wr_addr = sweep_q;
    wr_data = sweep_val;
    unique case (cmd_i.op)
      DP_SWEEP: begin
        wr_en = 1'b1;
      end
      DP_CHECK: begin
        rd_addr = {node_q[BIN_W-1:0], 1'b0};
      end
      DP_DESC: begin
        // At the bottom level read the chosen bin itself, else its left child.
        rd_addr = child[BIN_W] ? child : {child[BIN_W-1:0], 1'b0};
      end
      DP_LEAF: begin
        rd_addr = node_q ^ TREE_AW'(1);
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = leaf_new;
      end
      DP_ASCEND: begin
        rd_addr = parent ^ TREE_AW'(1);
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = up_val;
      end
      default: begin
        rd_addr = TREE_AW'(1);
      end
    endcase
  end

  // Tree memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Configuration, live settings and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cap_q  <= CAP_W'(DEF_CAPACITY);
      cfg_cnt_q  <= COUNT_W'(DEF_COUNT);
      live_cap_q <= SIZE_WIDTH'(DEF_CAPACITY);
      live_cnt_q <= CNT_W'(InitCount);
      hu_q       <= '0;
      vol_q      <= '0;
      sweep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_CAPACITY: cfg_cap_q <= cfg_data_i;
          REG_COUNT:    cfg_cnt_q <= cfg_data_i[COUNT_W-1:0];
        endcase
      end
      if (cmd_i.op == DP_RESTART) begin
        live_cap_q <= SIZE_WIDTH'(cfg_cap_q);
        live_cnt_q <= cnt_clamped;
        hu_q       <= '0;
        vol_q      <= '0;
      end
      if (cmd_i.op == DP_SWEEP) begin
        sweep_q <= sweep_q + TREE_AW'(1);
      end
      if (cmd_i.op == DP_LEAF) begin
        hu_q  <= hu_d;
        vol_q <= vol_q + SLACK_W'(size_q);
      end
    end
  end

  // Request path and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_PLACE || cmd_i.op == DP_RESTART) begin
      size_q <= item_size_i;
      bin_q  <= '0;
      fits_q <= 1'b0;
    end
    if (cmd_i.op == DP_ROOT) begin
      node_q <= TREE_AW'(1);
    end
    if (cmd_i.op == DP_DESC) begin
      node_q <= child;
    end
    if (cmd_i.op == DP_LEAF) begin
      cur_q  <= leaf_new;
      bin_q  <= node_q[BIN_W-1:0];
      fits_q <= 1'b1;
    end
    if (cmd_i.op == DP_ASCEND) begin
      cur_q  <= up_val;
      node_q <= parent;
    end
    if (cmd_i.op == DP_MUL) begin
      prod_q <= prod_ext[SLACK_W-1:0];
    end
    if (cmd_i.op == DP_LOAD) begin
      bin_index_q <= bin_ext[IDX_W-1:0];
      fits_out_q  <= fits_q;
      used_bins_q <= hu_ext[USED_W-1:0];
      slack_q     <= prod_q - vol_q;
    end
  end

  assign bin_index_o   = bin_index_q;
  assign fits_o        = fits_out_q;
  assign used_bins_o   = used_bins_q;
  assign slack_total_o = slack_q;

endmodule

/* rtl/first_fit_bin_allocator.sv */
// First-fit bin allocator: top level joining the sequencer and the datapath.
//
// Requests arrive on the input channel (in_valid_i, in_stall_o, operation_i,
// item_size_i). A place request puts the item into the leftmost bin with room;
// a restart request refills every bin with the capacity and count written last.
// Every request gives one beat on the output channel (out_valid_o,
// out_stall_i) with the chosen bin, the fits flag, the used bins
// and the total slack. The user writes registers on the cfg port only while the block
// is idle; the block does not enforce this. They take effect at the next restart.
// A place request goes from its accept beat to its result in steps: one per tree
// level going down and one per level coming back up, each level one access to the
// single tree memory. A request that fits nowhere stops after the check at the root.
// A restart rewrites the whole tree, 2*MAX_BINS entries (rounded up to a power of
// two) one per cycle. The next request can be taken in the cycle after the result
// is loaded. After reset the same fill pass runs with capacity 100 and
// min(1024, MAX_BINS) bins in use; in_stall_o stays high meanwhile. A stalled
// result waits in the output register; the block then holds the following
// request's result until the register frees up.
module first_fit_bin_allocator #(
  parameter int MAX_BINS   = ffba_pkg::DEF_MAX_BINS,
  parameter int SIZE_WIDTH = ffba_pkg::DEF_SIZE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [SIZE_WIDTH-1:0]            item_size_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ffba_pkg::IDX_W-1:0]       bin_index_o,
  output logic                             fits_o,
  output logic [ffba_pkg::USED_W-1:0]      used_bins_o,
  output logic [ffba_pkg::SLACK_W-1:0]     slack_total_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ffba_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ffba_dpath #(
    .MAX_BINS   (MAX_BINS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_size_i   (item_size_i),
    .bin_index_o   (bin_index_o),
    .fits_o        (fits_o),
    .used_bins_o   (used_bins_o),
    .slack_total_o (slack_total_o)
  );

endmodule

/* test/first_fit_bin_allocator_tb.sv */
// Self-checking testbench for the first-fit bin allocator, with a scoreboard class.
`timescale 1ns / 1ps

module first_fit_bin_allocator_tb;
  import ffba_pkg::*;

  localparam int BINS         = DEF_MAX_BINS;
  localparam int SIZE_W       = DEF_SIZE_WIDTH;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 350;
  localparam int FILL_ITEMS   = 1150;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [IDX_W-1:0]   bin_index;
    logic               fits;
    logic [USED_W-1:0]  used_bins;
    logic [SLACK_W-1:0] slack_total;
  } alloc_result_t;

  // Mirrors the bin contents and predicts one result per accepted request.
  class alloc_scoreboard;
    logic [CAP_W-1:0] bin_room [BINS];
    int unsigned      stored_cap, stored_cnt;
    int unsigned      active_cap, active_cnt;
    int unsigned      high_mark;
    longint unsigned  volume;
    alloc_result_t    awaited [$];
    int unsigned      errors, places, fitted, restarts, peak_used, checked;

    function new();
      stored_cap = DEF_CAPACITY;
      stored_cnt = DEF_COUNT;
      refill_bins();
    endfunction

    // The stored registers become live only here, as at reset.
    function void refill_bins();
      active_cnt = (stored_cnt == 0) ? 1 : ((stored_cnt > BINS) ? BINS : stored_cnt);
      active_cap = stored_cap;
      foreach (bin_room[b]) bin_room[b] = CAP_W'(active_cap);
      high_mark = 0;
      volume    = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CAPACITY: stored_cap = data;
        REG_COUNT:    stored_cnt = data[COUNT_W-1:0];
        default:      ;
      endcase
    endfunction

    // Leftmost bin with enough room takes the item; no room leaves all state alone.
    function void note_request(oper_e op, logic [SIZE_W-1:0] size);
      alloc_result_t res;
      int unsigned   b;
      res = '0;
      if (op == OPER_RESTART) begin
        refill_bins();
        restarts++;
      end else begin
        places++;
        b = 0;
        while (b < active_cnt && bin_room[b] < size) b++;
        if (b < active_cnt) begin
          bin_room[b] -= size;
          volume += size;
          if (b + 1 > high_mark) high_mark = b + 1;
          if (high_mark > peak_used) peak_used = high_mark;
          res.bin_index = b[IDX_W-1:0];
          res.fits      = 1'b1;
          fitted++;
        end
        res.used_bins   = high_mark[USED_W-1:0];
        res.slack_total = SLACK_W'(longint'(high_mark) * longint'(active_cap) - volume);
      end
      awaited.push_back(res);
    endfunction

    function void compare_field(string field, logic [SLACK_W-1:0] want,
                                logic [SLACK_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual bin %0d fits %0d used %0d slack %0d",
                 $time, got.bin_index, got.fits, got.used_bins, got.slack_total);
        return;
      end
      want = awaited.pop_front();
      compare_field("bin_index", want.bin_index, got.bin_index);
      compare_field("fits", want.fits, got.fits);
      compare_field("used_bins", want.used_bins, got.used_bins);
      compare_field("slack_total", want.slack_total, got.slack_total);
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic                    operation_i   = OPER_PLACE;
  logic [SIZE_W-1:0]       item_size_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic [IDX_W-1:0]        bin_index_o;
  logic                    fits_o;
  logic [USED_W-1:0]       used_bins_o;
  logic [SLACK_W-1:0]      slack_total_o;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = REG_CAPACITY;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;

  alloc_scoreboard board;
  bit              hold_request = 1'b0;
  int unsigned     hold_count   = 0;
  int unsigned     reg_writes   = 0;
  int unsigned     cycle_count  = 0;

  first_fit_bin_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .item_size_i   (item_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bin_index_o   (bin_index_o),
    .fits_o        (fits_o),
    .used_bins_o   (used_bins_o),
    .slack_total_o (slack_total_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Every result beat taken by the receiver goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(alloc_result_t'{bin_index_o, fits_o, used_bins_o, slack_total_o});
  end

  // Receiver: alternating stall bursts, free-running stretches and rare long hold-offs.
  initial begin : receiver
    int unsigned run_len, k, r;
    bit          stalled;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count++;
        stalled = 1'b1;
        run_len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          stalled = 1'b0;
          run_len = $urandom_range(100, 300);
        end else if (r < 60) begin
          stalled = 1'b0;
          run_len = $urandom_range(1, 12);
        end else if (r < 92) begin
          stalled = 1'b1;
          run_len = $urandom_range(1, 4);
        end else begin
          stalled = 1'b1;
          run_len = $urandom_range(10, 60);
        end
      end
      out_stall_i <= stalled;
      k = 0;
      do begin
        @(posedge clk_i);
        k++;
      end while (k < run_len && !hold_request);
    end
  end

  // Idle cycles after a beat: mostly none or a few, now and then a long pause.
  function automatic int unsigned pick_gap(bit busy);
    int unsigned r;
    if (busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sizes cluster around the capacity so bins fill up and misses happen.
  function automatic logic [SIZE_W-1:0] pick_size(int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return SIZE_W'($urandom_range(0, cap));
    if (r < 65) return SIZE_W'($urandom_range(0, cap / 4));
    if (r < 75) return SIZE_W'(cap);
    if (r < 80) return '0;
    if (r < 88) return SIZE_W'(cap + 1);
    return SIZE_W'($urandom);
  endfunction

  task automatic send_request(oper_e op, logic [SIZE_W-1:0] size, int unsigned gap);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    item_size_i <= size;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(op, size);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering requests and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.awaited.size() != 0);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] cnt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_CAPACITY;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(REG_CAPACITY, cap);
    cfg_index_i <= REG_COUNT;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(REG_COUNT, cnt);
    cfg_valid_i <= 1'b0;
    reg_writes += 2;
  endtask

  initial begin : stimulus
    int unsigned sent, n, i, kind, cap, phases, r;
    logic [CFG_DATA_W-1:0] cnt;
    bit busy;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // New registers must not act before a restart: reset capacity and count still hold.
    write_regs(10, 3);
    send_request(OPER_PLACE, 100, 1);
    send_request(OPER_PLACE, 100, 0);
    send_request(OPER_PLACE, 100, 1);
    send_request(OPER_PLACE, 100, 0);
    send_request(OPER_PLACE, 0, 1);
    send_request(OPER_PLACE, 16'hFFFF, 0);
    send_request(OPER_PLACE, 1, 2);

    // Restart latches capacity 10 over three bins; fill them and miss.
    send_request(OPER_RESTART, 16'h5A5A, 1);
    send_request(OPER_PLACE, 11, 0);
    send_request(OPER_PLACE, 10, 0);
    send_request(OPER_PLACE, 10, 1);
    send_request(OPER_PLACE, 10, 0);
    send_request(OPER_PLACE, 1, 0);
    drain_results();

    // Zero capacity with a zero count: one empty bin, only zero-size items fit.
    write_regs(0, 0);
    send_request(OPER_RESTART, 0, 0);
    send_request(OPER_PLACE, 1, 0);
    send_request(OPER_PLACE, 0, 1);
    drain_results();

    // Largest capacity and an oversized count with every data bit set.
    write_regs(16'hFFFF, 16'hFFFF);
    send_request(OPER_RESTART, 16'hFFFF, 0);
    send_request(OPER_PLACE, 16'hFFFF, 0);
    send_request(OPER_PLACE, 16'hFFFF, 1);
    send_request(OPER_PLACE, 16'h8000, 0);
    send_request(OPER_PLACE, 16'h7FFF, 0);
    send_request(OPER_PLACE, 0, 0);
    drain_results();

    // Unit bins across the whole array, so the used count reaches its top.
    write_regs(1, CFG_DATA_W'(BINS));
    send_request(OPER_RESTART, SIZE_W'($urandom), 0);
    for (i = 0; i < FILL_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      send_request(OPER_PLACE,
                   (r < 90) ? SIZE_W'(1) : ((r < 94) ? SIZE_W'(0) : SIZE_W'($urandom)),
                   pick_gap(i % 200 < 40));
    end
    sent = FILL_ITEMS + 1;

    // Random phases, each with its own register setting and a restart first.
    phases = 0;
    while (sent < RANDOM_ITEMS + FILL_ITEMS) begin
      drain_results();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin cap = $urandom_range(0, 3);     cnt = CFG_DATA_W'($urandom_range(1, 4));     end
        5: begin cap = $urandom_range(0, 65535); cnt = CFG_DATA_W'($urandom_range(1, 64));    end
        6: begin cap = 65535;                    cnt = CFG_DATA_W'(BINS);                     end
        7: begin cap = $urandom_range(1, 1000);  cnt = CFG_DATA_W'($urandom_range(0, 65535)); end
        8: begin cap = $urandom_range(0, 65535); cnt = '0;                                    end
        9: begin cap = $urandom_range(1, 50);    cnt = CFG_DATA_W'($urandom_range(100, BINS)); end
        default: begin
          cap = $urandom_range(1, 200);
          cnt = CFG_DATA_W'($urandom_range(1, 12));
        end
      endcase
      write_regs(CFG_DATA_W'(cap), cnt);
      busy = ($urandom_range(0, 3) == 0);
      send_request(OPER_RESTART, SIZE_W'($urandom), 0);
      n = $urandom_range(15, 50);

      // Long receiver hold-off while the sender keeps offering, so the block backs up.
      if (phases == 0 || $urandom_range(0, 5) == 0) begin
        drain_results();
        hold_request = 1'b1;
        busy = 1'b1;
        n = $urandom_range(30, 50);
      end

      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 3)
          send_request(OPER_RESTART, SIZE_W'($urandom), pick_gap(busy));
        else
          send_request(OPER_PLACE, pick_size(cap), pick_gap(busy));
      end
      sent += n + 1;
      phases++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d placements (%0d fitted), %0d restarts, %0d phases.",
             board.places + board.restarts, board.places, board.fitted, board.restarts,
             phases);
    $display("Checked %0d results; %0d register writes, %0d long hold-offs, peak used %0d.",
             board.checked, reg_writes, hold_count, board.peak_used);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* first_fit_bin_allocator.f */
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dpath.sv
rtl/first_fit_bin_allocator.sv
test/first_fit_bin_allocator_tb.sv
